// ===== rtl/qpht_pkg.sv =====
// Shared constants and types for the quadratic probing hash table.
package qpht_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int SIZE_W     = IDX_W + 1;
  localparam int CFG_W      = 11;
  localparam int VAL_W      = 31;
  localparam int CNT_W      = 11;
  localparam int STAT_W     = 3;
  localparam int FUNC_W     = 2;
  localparam int BIT_W      = $clog2(VAL_W);
  localparam int IN_DATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((IDX_W + VAL_W + CNT_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]  SIZE_RESET = CFG_W'(11);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SLOTS);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HOME    = 3'd0,
    ST_COLL    = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4,
    ST_CLEARED = 3'd5,
    ST_READ    = 3'd6
  } status_t;

endpackage

// ===== rtl/qpht_addmod.sv =====
// Shared modular add unit: (a + b + cin) reduced by one conditional subtract of m.
module qpht_addmod (
  input  logic [qpht_pkg::SIZE_W-1:0] a,
  input  logic [qpht_pkg::SIZE_W-1:0] b,
  input  logic                        cin,
  input  logic [qpht_pkg::SIZE_W-1:0] m,
  output logic [qpht_pkg::SIZE_W-1:0] y
);
  import qpht_pkg::*;

  logic [SIZE_W:0] sum;
  logic [SIZE_W:0] diff;

  // Both operands stay below m, so the sum is below 2m and one subtract suffices.
  assign sum  = {1'b0, a} + {1'b0, b} + {{SIZE_W{1'b0}}, cin};
  assign diff = sum - {1'b0, m};
  assign y    = (sum >= {1'b0, m}) ? diff[SIZE_W-1:0] : sum[SIZE_W-1:0];

endmodule

// ===== rtl/qpht_slot_ram.sv =====
// Slot storage: one write port and one registered read port.
module qpht_slot_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [qpht_pkg::IDX_W-1:0] waddr,
  input  logic [qpht_pkg::VAL_W-1:0] wdata,
  input  logic [qpht_pkg::IDX_W-1:0] raddr,
  output logic [qpht_pkg::VAL_W-1:0] rdata
);
  import qpht_pkg::*;

  logic [VAL_W-1:0] mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/quadratic_probe_hash_table.sv =====
// Top level of the quadratic probing hash table with its operation sequencer.
//
//  Channel  Direction  Handshake            Contents
//  cfg      in         cfg_we               table_size in cfg_wdata
//  s_*      in         s_tvalid / s_tready  func in tuser, operand in tdata
//  m_*      out        m_tvalid / m_tready  status in tuser; index, value, count in tdata
//
// After reset the block clears all 1024 slots, one per cycle, before it raises s_tready.
// Read and delete pass through the accepting cycle, a bit-serial modulo over all 31
// operand bits in the shared add unit, a slot read, a check and the result hand-off.
// Insert runs the same steps and adds three add steps, a read and a check per collision;
// a full table stops at the size-th taken slot and then reads the home slot for the report.
// Clear writes one slot per cycle for all 1024 slots.
// A finished word waits in the output register while the next word is accepted.
module quadratic_probe_hash_table (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [qpht_pkg::CFG_W-1:0]      cfg_wdata,
  // Input words.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [qpht_pkg::IN_DATA_W-1:0]  s_tdata,   // operand[30:0], zero pad
  input  logic [qpht_pkg::FUNC_W-1:0]     s_tuser,   // func[1:0]
  // Result words.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [qpht_pkg::OUT_DATA_W-1:0] m_tdata,   // slot_index, slot_value, probe_count, pad
  output logic [qpht_pkg::STAT_W-1:0]     m_tuser    // status[2:0]
);
  import qpht_pkg::*;

  typedef enum logic [11:0] {
    S_INIT    = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_DIV     = 12'b0000_0000_0100,
    S_RD      = 12'b0000_0000_1000,
    S_CHK     = 12'b0000_0001_0000,
    S_SQ      = 12'b0000_0010_0000,
    S_ODD     = 12'b0000_0100_0000,
    S_POS     = 12'b0000_1000_0000,
    S_FULLRD  = 12'b0001_0000_0000,
    S_FULLCHK = 12'b0010_0000_0000,
    S_CLR     = 12'b0100_0000_0000,
    S_OUT     = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  table_size;
  logic [SIZE_W-1:0] size_cfg;
  logic [SIZE_W-1:0] size_op;     // size in use, latched when a word is accepted
  func_t             func;
  logic [VAL_W-1:0]  opnd;
  logic [BIT_W-1:0]  bitcnt;
  logic [SIZE_W-1:0] pos;         // remainder during the modulo, probe slot afterwards
  logic [SIZE_W-1:0] home;
  logic [SIZE_W-1:0] k;
  logic [SIZE_W-1:0] k_inc;
  logic [SIZE_W-1:0] sq;          // k*k mod size
  logic [SIZE_W-1:0] odd;         // (2k+1) mod size, the step to the next square
  logic [IDX_W-1:0]  clr_addr;

  status_t           res_status;
  logic [IDX_W-1:0]  res_index;
  logic [VAL_W-1:0]  res_value;
  logic [CNT_W-1:0]  res_count;

  // Shared add unit operands.
  logic [SIZE_W-1:0] unit_a;
  logic [SIZE_W-1:0] unit_b;
  logic              unit_cin;
  logic [SIZE_W-1:0] unit_y;

  // Slot memory port.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;

  // The configured size is clamped into the legal range of 2 to MAX_SLOTS.
  always_comb begin
    if ({1'b0, table_size} < {1'b0, SIZE_W'(SIZE_MIN)}) begin
      size_cfg = SIZE_MIN;
    end else if ({1'b0, table_size} > {1'b0, SIZE_W'(SIZE_MAX)}) begin
      size_cfg = SIZE_MAX;
    end else begin
      size_cfg = SIZE_W'(table_size);
    end
  end

  assign k_inc    = k + SIZE_W'(1);
  assign s_tready = (state == S_IDLE);

  // The one add-and-reduce unit serves the modulo steps and all probe arithmetic.
  always_comb begin
    unit_a   = pos;
    unit_b   = pos;
    unit_cin = 1'b0;
    unique case (state)
      S_DIV: begin
        unit_a   = pos;
        unit_b   = pos;
        unit_cin = opnd[bitcnt];
      end
      S_SQ: begin
        unit_a = sq;
        unit_b = odd;
      end
      S_ODD: begin
        unit_a = odd;
        unit_b = SIZE_W'(2);
      end
      S_POS: begin
        unit_a = pos;
        unit_b = sq;
      end
      default: begin
        unit_a = pos;
      end
    endcase
  end

  qpht_addmod u_addmod (
    .a   (unit_a),
    .b   (unit_b),
    .cin (unit_cin),
    .m   (size_op),
    .y   (unit_y)
  );

  // Memory writes come from the clearing sweep or from the check of a probed slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[IDX_W-1:0];
    ram_wdata = '0;
    if (state == S_INIT || state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (state == S_CHK) begin
      if (func == FN_INSERT && ram_rdata == '0) begin
        ram_we    = 1'b1;
        ram_wdata = opnd;
      end else if (func == FN_DELETE && ram_rdata != '0) begin
        ram_we    = 1'b1;
      end
    end
  end

  qpht_slot_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      clr_addr   <= '0;
      table_size <= SIZE_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size <= cfg_wdata;
      end
      // In the hand-off state the valid is driven by the state itself.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state) inside
        S_INIT, S_CLR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(MAX_SLOTS - 1)) begin
            if (state == S_INIT) begin
              state <= S_IDLE;
            end else begin
              res_status <= ST_CLEARED;
              res_index  <= '0;
              res_value  <= '0;
              res_count  <= '0;
              state      <= S_OUT;
            end
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            func    <= func_t'(s_tuser);
            opnd    <= s_tdata[VAL_W-1:0];
            size_op <= size_cfg;
            pos     <= '0;
            bitcnt  <= BIT_W'(VAL_W - 1);
            state   <= (func_t'(s_tuser) == FN_CLEAR) ? S_CLR : S_DIV;
          end
        end
        S_DIV: begin
          // Restoring modulo, one operand bit per cycle, most significant first.
          pos    <= unit_y;
          bitcnt <= bitcnt - BIT_W'(1);
          if (bitcnt == '0) begin
            home  <= unit_y;
            k     <= '0;
            sq    <= '0;
            odd   <= SIZE_W'(1);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          case (func)
            FN_INSERT: begin
              if (ram_rdata == '0) begin
                res_status <= (k == '0) ? ST_HOME : ST_COLL;
                res_index  <= pos[IDX_W-1:0];
                res_value  <= opnd;
                res_count  <= CNT_W'(k);
                state      <= S_OUT;
              end else if (k_inc >= size_op) begin
                // Every probe hit a taken slot: report the home slot as it stands.
                k     <= k_inc;
                pos   <= home;
                state <= S_FULLRD;
              end else begin
                k     <= k_inc;
                state <= S_SQ;
              end
            end
            FN_DELETE: begin
              res_status <= (ram_rdata == '0) ? ST_ABSENT : ST_REMOVED;
              res_index  <= pos[IDX_W-1:0];
              res_value  <= '0;
              res_count  <= '0;
              state      <= S_OUT;
            end
            FN_READ: begin
              res_status <= ST_READ;
              res_index  <= pos[IDX_W-1:0];
              res_value  <= ram_rdata;
              res_count  <= '0;
              state      <= S_OUT;
            end
            default: begin
              res_status <= ST_CLEARED;
              res_index  <= '0;
              res_value  <= '0;
              res_count  <= '0;
              state      <= S_OUT;
            end
          endcase
        end
        S_SQ: begin
          sq    <= unit_y;
          state <= S_ODD;
        end
        S_ODD: begin
          odd   <= unit_y;
          state <= S_POS;
        end
        S_POS: begin
          pos   <= unit_y;
          state <= S_RD;
        end
        S_FULLRD: begin
          state <= S_FULLCHK;
        end
        S_FULLCHK: begin
          res_status <= ST_FULL;
          res_index  <= home[IDX_W-1:0];
          res_value  <= ram_rdata;
          res_count  <= CNT_W'(size_op);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload register, loaded as the result word is handed over.
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= res_status;
      m_tdata <= OUT_DATA_W'({res_count, res_value, res_index});
    end
  end

  // The remainder never reaches the modulus while the operand is reduced.
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> pos < size_op)
    else $error("modulo remainder out of range");

  // Every probed slot lies inside the table in use.
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> (pos < size_op && home < size_op))
    else $error("probe slot out of range");

  // Probing continues only while fewer than size probes have been made.
  a_probe_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_SQ |-> (k < size_op && k != '0))
    else $error("probe count past the table size");

  // An accepted word starts either the modulo or the clearing sweep at slot zero.
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> (state == S_DIV || (state == S_CLR && clr_addr == '0)))
    else $error("accepted word did not start an operation");

endmodule

// ===== test/qpht_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the quadratic probing hash table: slot tracking and word compare.
module qpht_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qpht_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [qpht_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [qpht_pkg::FUNC_W-1:0]     s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [qpht_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [qpht_pkg::STAT_W-1:0]     m_tuser,
  output int                              mismatches,
  output int                              pending
);
  import qpht_pkg::*;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] probes;
  } slot_result_t;

  logic [VAL_W-1:0] slot_mem [MAX_SLOTS];
  logic [CFG_W-1:0] size_reg;
  slot_result_t     results_due [$];
  int               errors = 0;

  // Slots in use; out-of-range register values saturate.
  function automatic int unsigned active_size();
    if (size_reg < 2) return 2;
    if (size_reg > MAX_SLOTS) return MAX_SLOTS;
    return size_reg;
  endfunction

  // Applies one operation to the tracked slots and returns the word it should produce.
  function automatic slot_result_t apply_op(input func_t fn, input logic [VAL_W-1:0] key);
    slot_result_t r;
    int unsigned  sz, home, pos, k;
    int           i;
    sz       = active_size();
    home     = key % sz;
    r.status = ST_READ;
    r.index  = IDX_W'(home);
    r.value  = slot_mem[home];
    r.probes = '0;
    case (fn)
      FN_INSERT: begin
        pos = home;
        k   = 0;
        while (k < sz && slot_mem[pos] != '0) begin
          k++;
          pos = (pos + (k * k) % sz) % sz;
        end
        if (k >= sz) begin
          r.status = ST_FULL;
          r.probes = CNT_W'(sz);
        end else begin
          slot_mem[pos] = key;
          r.status = (k == 0) ? ST_HOME : ST_COLL;
          r.index  = IDX_W'(pos);
          r.value  = key;
          r.probes = CNT_W'(k);
        end
      end
      FN_DELETE: begin
        r.status = (slot_mem[home] == '0) ? ST_ABSENT : ST_REMOVED;
        slot_mem[home] = '0;
        r.value = '0;
      end
      FN_CLEAR: begin
        for (i = 0; i < MAX_SLOTS; i++) slot_mem[i] = '0;
        r.status = ST_CLEARED;
        r.index  = '0;
        r.value  = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    slot_result_t     want;
    logic [IDX_W-1:0] got_index;
    logic [VAL_W-1:0] got_value;
    logic [CNT_W-1:0] got_probes;
    int               i;
    if (rst) begin
      size_reg = SIZE_RESET;
      for (i = 0; i < MAX_SLOTS; i++) slot_mem[i] = '0;
      results_due.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      if (s_tvalid && s_tready)
        results_due.push_back(apply_op(func_t'(s_tuser), s_tdata[VAL_W-1:0]));
      if (m_tvalid && m_tready) begin
        got_index  = m_tdata[IDX_W-1:0];
        got_value  = m_tdata[IDX_W +: VAL_W];
        got_probes = m_tdata[IDX_W+VAL_W +: CNT_W];
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected word: status %0d index %0d value 0x%08h probes %0d",
                     $realtime, m_tuser, got_index, got_value, got_probes);
        end else begin
          want = results_due.pop_front();
          if (m_tuser !== want.status || got_index !== want.index ||
              got_value !== want.value || got_probes !== want.probes) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: word mismatch", $realtime);
              $display("  expected status %0d index %0d value 0x%08h probes %0d",
                       want.status, want.index, want.value, want.probes);
              $display("  actual   status %0d index %0d value 0x%08h probes %0d",
                       m_tuser, got_index, got_value, got_probes);
            end
          end
        end
      end
    end
    mismatches <= errors;
    pending    <= results_due.size();
  end

endmodule

// ===== test/tb_quadratic_probe_hash_table.sv =====
`timescale 1ns / 100ps
// Testbench top for the quadratic probing hash table: stimulus, flow control and verdict.
module tb_quadratic_probe_hash_table;
  import qpht_pkg::*;

  // The limit covers an insert that walks all 1024 slots together with the receiver
  // hold-off, and leaves a wide margin over both.
  localparam int WATCHDOG_LIMIT  = 40000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_TAIL      = 40;
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_ITEMS     = 86;
  localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;    // operand[30:0], zero pad
  logic [FUNC_W-1:0]     s_tuser;    // func[1:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;    // slot_index[9:0], slot_value[40:10], probe_count[51:41], pad
  logic [STAT_W-1:0]     m_tuser;    // status[2:0]

  int mismatches;
  int pending;
  int idle_cycles = 0;

  // Flow control shared between the stimulus and the result sink.
  bit stalls_on       = 1'b1;
  int hold_off_asked  = 0;
  int hold_off_served = 0;

  // Effective table size and a pool of keys that were recently inserted, so that
  // many deletes and colliding inserts hit occupied slots.
  int unsigned eff_size = 11;
  int unsigned live_keys [$];

  quadratic_probe_hash_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  qpht_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut short when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[quadratic_probe_hash_table] ERROR");
      $finish;
    end
  end

  // Result sink. Each pass makes exactly one assignment to m_tready and then waits
  // at least one edge. A requested hold-off keeps it low long enough for the block
  // to fill its output register, finish the next word and stall its input.
  initial begin : sink
    forever begin
      if (hold_off_served < hold_off_asked) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_served++;
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offers one word and returns at the edge where it is accepted. The valid stays
  // high so that a following word can be presented in the same step without a bubble.
  task automatic send_word(input func_t fn, input logic [VAL_W-1:0] operand);
    s_tuser  <= fn;
    s_tdata  <= IN_DATA_W'(operand);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops offering and waits until every expected word has come back. The first
  // edge lets the checker's count include a word accepted in this very step.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_size(input logic [CFG_W-1:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff_size = (value < 2) ? 2 : (value > MAX_SLOTS) ? MAX_SLOTS : value;
  endtask

  task automatic sender_gap();
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Register values for the random phases. Most are small primes; the extremes
  // (zero, the largest prime below the slot count, the slot count, all ones) are
  // spread among them so that saturation and large tables are both exercised.
  function automatic logic [CFG_W-1:0] phase_size(input int p);
    case (p)
      0:       return 13;
      1:       return 3;
      2:       return 7;
      3:       return 1021;
      4:       return 5;
      5:       return 0;
      6:       return 31;
      7:       return 2047;
      8:       return 2;
      9:       return 97;
      10:      return 1024;
      default: return 11;
    endcase
  endfunction

  // One random word. Inserts dominate and often aim at home slots of keys already
  // in the table, deletes mostly name a live key, reads cover the table and beyond,
  // and an occasional clear resets the contents.
  task automatic random_op();
    int unsigned pick;
    int unsigned mode;
    int unsigned key;
    int          idx;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: key = $urandom;
        1: key = $urandom_range(1, 4 * eff_size);
        2: begin
          if (live_keys.size() > 0) begin
            key = live_keys[$urandom_range(0, live_keys.size() - 1)] +
                  eff_size * $urandom_range(1, 50);
          end else begin
            key = $urandom_range(0, eff_size - 1);
          end
        end
        default: key = $urandom_range(0, eff_size - 1);
      endcase
      key = key & VAL_ALL_ONES;
      if (key != 0) begin
        live_keys.push_back(key);
        if (live_keys.size() > 256) live_keys.delete(0);
      end
      send_word(FN_INSERT, key[VAL_W-1:0]);
    end else if (pick < 65) begin
      if (live_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
        idx = $urandom_range(0, live_keys.size() - 1);
        key = live_keys[idx];
        live_keys.delete(idx);
      end else if ($urandom_range(0, 1) != 0) begin
        key = $urandom_range(0, 2 * eff_size);
      end else begin
        key = $urandom & VAL_ALL_ONES;
      end
      send_word(FN_DELETE, key[VAL_W-1:0]);
    end else if (pick < 97) begin
      if ($urandom_range(0, 2) != 0) begin
        key = $urandom_range(0, eff_size - 1);
      end else begin
        key = $urandom & VAL_ALL_ONES;
      end
      send_word(FN_READ, key[VAL_W-1:0]);
    end else begin
      live_keys.delete();
      key = $urandom & VAL_ALL_ONES;
      send_word(FN_CLEAR, key[VAL_W-1:0]);
    end
  endtask

  initial begin : stimulus
    int p;
    int n;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= FN_INSERT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 11. The block clears its slots after
    // reset, so the first word simply waits for s_tready.
    send_word(FN_INSERT, 5);             // lands in its home slot
    send_word(FN_INSERT, 16);            // same home, one step further on
    send_word(FN_INSERT, 0);             // zero is placed but leaves the slot free
    send_word(FN_READ, 5);
    send_word(FN_READ, VAL_ALL_ONES);    // index far beyond the table wraps
    send_word(FN_DELETE, 27);            // removes 5 without comparing the key
    send_word(FN_DELETE, 27);            // home slot is now empty
    send_word(FN_INSERT, VAL_ALL_ONES);
    send_word(FN_INSERT, 31'h5555_5555);
    send_word(FN_CLEAR, 31'h2AAA_AAAA);

    // A zero size acts as two: the third insert finds both slots taken.
    set_size(0);
    send_word(FN_INSERT, 2);
    send_word(FN_INSERT, 3);
    send_word(FN_INSERT, 4);
    send_word(FN_DELETE, 5);

    // A size of one also acts as two.
    set_size(1);
    send_word(FN_INSERT, 9);

    // All ones saturates at the slot count. Old contents stay where they were,
    // so the insert collides twice, and slots beyond the old size read back free.
    set_size(2047);
    send_word(FN_INSERT, 1024);
    send_word(FN_READ, 1025);
    send_word(FN_READ, 1023);
    send_word(FN_DELETE, 2048);

    // With five slots the probe walk from slot 0 only visits slots 0, 1 and 4,
    // so the table reports full while slot 3 is still free.
    set_size(5);
    send_word(FN_INSERT, 5);
    send_word(FN_INSERT, 1);
    send_word(FN_INSERT, 4);
    send_word(FN_INSERT, 10);

    // Random phases, each at its own size. The last two run without any idling.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      set_size(phase_size(p));
      stalls_on = (p < RANDOM_PHASES - 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Back pressure: the sink holds off while words keep coming back to back.
        if (p == 2 && n == 30) hold_off_asked++;
        // Mid-phase pause with every result collected before going on.
        if (p == 4 && n == 40) drain();
        random_op();
        if (!(p == 2 && n >= 30 && n < 45)) sender_gap();
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[quadratic_probe_hash_table] OK");
    end else begin
      $display("[quadratic_probe_hash_table] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qpht_pkg.sv
rtl/qpht_addmod.sv
rtl/qpht_slot_ram.sv
rtl/quadratic_probe_hash_table.sv
test/qpht_checker.sv
test/tb_quadratic_probe_hash_table.sv
